/* hdl/sms_pkg.sv */
// Shared constants, types and helpers for the substring match block.
package sms_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int MAX_TEXT    = 65536;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 6;
  localparam int IDX_W   = $clog2(MAX_PATTERN);
  localparam int POS_W   = $clog2(MAX_TEXT);
  localparam int WORD_W  = 64;
  localparam int PAT_W   = MAX_PATTERN * BYTE_W;
  localparam int ADDR_W  = 6;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TEXT - 1);

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_LEN  = 3'd0;
  localparam logic [2:0] REG_PAT0 = 3'd1;
  localparam logic [2:0] REG_PAT1 = 3'd2;
  localparam logic [2:0] REG_PAT2 = 3'd3;
  localparam logic [2:0] REG_PAT3 = 3'd4;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] start;
  } result_t;

  function automatic logic [BYTE_W-1:0] pattern_byte(
    input logic [PAT_W-1:0] pat,
    input logic [IDX_W-1:0] idx
  );
    pattern_byte = pat[idx*BYTE_W +: BYTE_W];
  endfunction

endpackage

/* hdl/substring_match_positions.sv */
// Top level of the streaming substring matcher.
//
// Text bytes enter on text_byte/end_of_text under text_valid/text_stall; an
// item is taken at an edge with text_valid high and text_stall low. One byte
// is taken every cycle while text_stall is low. Each byte that completes an
// occurrence of the pattern yields one registered item on match_start under
// match_valid/match_stall. A row of 31 cells holds the earlier bytes; each
// cell compares its byte with the pattern byte at its distance, so the whole
// pattern is checked in the cycle the newest byte arrives.
// The result sits in an output register backed by a skid register, so input
// keeps flowing while a result waits. When match_stall holds and both stages
// fill, text_stall rises until the receiver takes an item.
// Synchronous reset sets the pattern length to one, clears the pattern and
// the position counter and drops all pending results. Configuration is on
// an APB-style port with 64-bit registers at 8-byte spacing; write it only
// while no item is in flight.
module substring_match_positions
  import sms_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [WORD_W-1:0]  pwdata,
  output logic [WORD_W-1:0]  prdata,
  output logic               pready,
  input  logic               text_valid,
  output logic               text_stall,
  input  logic [BYTE_W-1:0]  text_byte,
  input  logic               end_of_text,
  output logic               match_valid,
  input  logic               match_stall,
  output logic [POS_W-1:0]   match_start
);

  logic [LEN_W-1:0]  pattern_length;
  logic [PAT_W-1:0]  pattern_bits;
  logic [2:0]        reg_idx;
  logic              cfg_wr;
  logic [IDX_W-1:0]  lm1;
  logic              accept;
  logic [POS_W-1:0]  pos;
  logic [BYTE_W-1:0] hist [0:MAX_PATTERN-2];
  logic [MAX_PATTERN-1:1] cell_ok;
  logic              cur_ok;
  logic              pos_ok;
  result_t           res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LEN_W'(1);
      pattern_bits   <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_LEN:  pattern_length <= pwdata[LEN_W-1:0];
        REG_PAT0: pattern_bits[0*WORD_W +: WORD_W] <= pwdata;
        REG_PAT1: pattern_bits[1*WORD_W +: WORD_W] <= pwdata;
        REG_PAT2: pattern_bits[2*WORD_W +: WORD_W] <= pwdata;
        REG_PAT3: pattern_bits[3*WORD_W +: WORD_W] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LEN:  prdata = {{(WORD_W-LEN_W){1'b0}}, pattern_length};
      REG_PAT0: prdata = pattern_bits[0*WORD_W +: WORD_W];
      REG_PAT1: prdata = pattern_bits[1*WORD_W +: WORD_W];
      REG_PAT2: prdata = pattern_bits[2*WORD_W +: WORD_W];
      REG_PAT3: prdata = pattern_bits[3*WORD_W +: WORD_W];
      default:  prdata = '0;
    endcase
  end

  // Effective length minus one: zero counts as one, anything too long as the maximum.
  always_comb begin
    if (pattern_length == '0) begin
      lm1 = '0;
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      lm1 = IDX_W'(MAX_PATTERN - 1);
    end else begin
      lm1 = IDX_W'(pattern_length - LEN_W'(1));
    end
  end

  assign accept = text_valid && !text_stall;
  assign hist[0] = text_byte;
  // The newest byte must equal the last pattern byte.
  assign cur_ok = (text_byte == pattern_byte(pattern_bits, lm1));

  for (genvar k = 1; k < MAX_PATTERN; k++) begin : g_cell
    logic [BYTE_W-1:0] dout;
    sms_cell u_cell (
      .clk    (clk),
      .shift  (accept),
      .din    (hist[k-1]),
      .pat    (pattern_byte(pattern_bits, lm1 - IDX_W'(k))),
      .active (IDX_W'(k) <= lm1),
      .dout   (dout),
      .ok     (cell_ok[k])
    );
    if (k < MAX_PATTERN - 1) begin : g_link
      assign hist[k] = dout;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      if (end_of_text) begin
        pos <= '0;
      end else if (pos != POS_MAX) begin
        pos <= pos + POS_W'(1);
      end
    end
  end

  // An occurrence needs all of its bytes inside the current text.
  assign pos_ok    = (pos >= POS_W'(lm1));
  assign res.hit   = accept && cur_ok && (&cell_ok) && pos_ok;
  assign res.start = pos - POS_W'(lm1);

  sms_out_buf u_out (
    .clk         (clk),
    .rst         (rst),
    .res         (res),
    .full        (text_stall),
    .match_valid (match_valid),
    .match_stall (match_stall),
    .match_start (match_start)
  );

endmodule

/* hdl/sms_cell.sv */
// One history cell: holds an earlier text byte, passes it on and checks it.
module sms_cell
  import sms_pkg::*;
(
  input  logic              clk,
  input  logic              shift,
  input  logic [BYTE_W-1:0] din,
  input  logic [BYTE_W-1:0] pat,
  input  logic              active,
  output logic [BYTE_W-1:0] dout,
  output logic              ok
);

  logic [BYTE_W-1:0] held;

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= din;
    end
  end

  assign dout = held;
  // A cell beyond the pattern length never blocks a match.
  assign ok = !active || (held == pat);

endmodule

/* hdl/sms_out_buf.sv */
// Output register with a skid stage for the match results.
module sms_out_buf
  import sms_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  result_t          res,
  output logic             full,
  output logic             match_valid,
  input  logic             match_stall,
  output logic [POS_W-1:0] match_start
);

  logic             skid_valid;
  logic [POS_W-1:0] skid_start;
  logic             take;

  assign take = match_valid && !match_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (skid_valid) begin
      // No item enters while the skid stage is occupied.
      if (take) begin
        match_start <= skid_start;
        skid_valid  <= 1'b0;
      end
    end else if (match_valid && !take) begin
      if (res.hit) begin
        skid_start <= res.start;
        skid_valid <= 1'b1;
      end
    end else begin
      match_valid <= res.hit;
      if (res.hit) begin
        match_start <= res.start;
      end
    end
  end

endmodule
